/* rtl/core/euler_rotation_matrix_q12_assert.svh */
// Assertion macros for the top RTL file of the rotation matrix block.
`ifndef EULER_ROTATION_MATRIX_Q12_ASSERT_SVH
`define EULER_ROTATION_MATRIX_Q12_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ERM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ERM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ERM_ASSERT(lbl, prop, msg)
`define ERM_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

/* rtl/core/erm_pkg.sv */
package erm_pkg;

  localparam int unsigned SinStages = 15;
  localparam int unsigned NumStages = SinStages + 4;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_t;

  function automatic logic signed [27:0] mul14(input logic signed [13:0] a,
                                               input logic signed [13:0] b);
    logic signed [27:0] ae;
    logic signed [27:0] be;
    ae = 28'(a);
    be = 28'(b);
    return ae * be;
  endfunction

  function automatic logic signed [15:0] rnd_clamp(input logic signed [27:0] s);
    logic [27:0]        mag;
    logic [16:0]        r;
    logic signed [17:0] rs;
    logic signed [15:0] res;
    mag = s[27] ? 28'(-s) : 28'(s);
    r   = 17'((mag + 28'd2048) >> 12);
    rs  = s[27] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (rs > 18'sd32767) begin
      res = 16'sd32767;
    end else if (rs < -18'sd32768) begin
      res = -16'sd32768;
    end else begin
      res = 16'(rs);
    end
    return res;
  endfunction

endpackage

/* rtl/core/euler_rotation_matrix_q12.sv */
// Euler rotation matrix unit, Q12.
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one transaction
// per angle triple, 4096 units per turn, only the low 12 bits of each angle used.
// The output channel (out_valid_o, out_ready_i, out_data_o) returns the nine
// entries of Ry*Rx*Rz in Q12, one transaction per input transaction, in order.
// From acceptance to out_valid_o the pipeline performs angle folding and setup,
// then a one-bit-per-stage divider for the six sines and cosines, then multiply
// and round for the two matrix products.
// Throughput is one transaction per cycle while the receiver takes results.
// Reset clears all stage valid bits; the pipeline then accepts at once.
// When the receiver stalls, the result holds on out_data_o and the stages behind
// it keep filling empty slots, so in_ready_o drops only once every stage holds
// a transaction.
module euler_rotation_matrix_q12 (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  erm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output erm_pkg::out_t out_data_o
);

  `include "euler_rotation_matrix_q12_assert.svh"

  localparam int unsigned NS = erm_pkg::NumStages;
  localparam int unsigned S1 = erm_pkg::SinStages;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_ready_o = en[0];

  logic [11:0]        ang [0:5];
  logic signed [13:0] sv  [0:5];

  assign ang[0] = in_data_i.angle_x[11:0];
  assign ang[1] = 12'(in_data_i.angle_x[11:0] + 12'd1024);
  assign ang[2] = in_data_i.angle_y[11:0];
  assign ang[3] = 12'(in_data_i.angle_y[11:0] + 12'd1024);
  assign ang[4] = in_data_i.angle_z[11:0];
  assign ang[5] = 12'(in_data_i.angle_z[11:0] + 12'd1024);

  for (genvar g = 0; g < 6; g++) begin : g_sin
    erm_sine u_sine (
      .clk_i   (clk_i),
      .en_i    (en[S1-1:0]),
      .angle_i (ang[g]),
      .sin_o   (sv[g])
    );
  end

  // sv order: sx, cx, sy, cy, sz, cz.
  logic signed [27:0] pss_q, psc_q, pcs_q, pcc_q;
  logic signed [13:0] cx1_q, sx1_q, cy1_q, sy1_q, cz1_q, sz1_q;

  always_ff @(posedge clk_i) begin
    if (en[S1]) begin
      pss_q <= erm_pkg::mul14(sv[2], sv[0]);
      psc_q <= erm_pkg::mul14(sv[2], sv[1]);
      pcs_q <= erm_pkg::mul14(sv[3], sv[0]);
      pcc_q <= erm_pkg::mul14(sv[3], sv[1]);
      sx1_q <= sv[0];
      cx1_q <= sv[1];
      sy1_q <= sv[2];
      cy1_q <= sv[3];
      sz1_q <= sv[4];
      cz1_q <= sv[5];
    end
  end

  logic signed [13:0] yx_q [0:2][0:2];
  logic signed [13:0] cz2_q, sz2_q;

  always_ff @(posedge clk_i) begin
    if (en[S1+1]) begin
      yx_q[0][0] <= cy1_q;
      yx_q[0][1] <= 14'(erm_pkg::rnd_clamp(pss_q));
      yx_q[0][2] <= 14'(erm_pkg::rnd_clamp(psc_q));
      yx_q[1][0] <= '0;
      yx_q[1][1] <= cx1_q;
      yx_q[1][2] <= -sx1_q;
      yx_q[2][0] <= -sy1_q;
      yx_q[2][1] <= 14'(erm_pkg::rnd_clamp(pcs_q));
      yx_q[2][2] <= 14'(erm_pkg::rnd_clamp(pcc_q));
      cz2_q      <= cz1_q;
      sz2_q      <= sz1_q;
    end
  end

  logic signed [27:0] acz_q [0:2];
  logic signed [27:0] bsz_q [0:2];
  logic signed [27:0] asz_q [0:2];
  logic signed [27:0] bcz_q [0:2];
  logic signed [13:0] c2_q  [0:2];
  logic signed [15:0] m_q   [0:2][0:2];

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en[S1+2]) begin
        acz_q[r] <= erm_pkg::mul14(yx_q[r][0], cz2_q);
        bsz_q[r] <= erm_pkg::mul14(yx_q[r][1], sz2_q);
        asz_q[r] <= erm_pkg::mul14(yx_q[r][0], sz2_q);
        bcz_q[r] <= erm_pkg::mul14(yx_q[r][1], cz2_q);
        c2_q[r]  <= yx_q[r][2];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[S1+3]) begin
        m_q[r][0] <= erm_pkg::rnd_clamp(acz_q[r] + bsz_q[r]);
        m_q[r][1] <= erm_pkg::rnd_clamp(bcz_q[r] - asz_q[r]);
        m_q[r][2] <= 16'(c2_q[r]);
      end
    end
  end

  assign out_valid_o    = v_q[NS-1];
  assign out_data_o.m00 = m_q[0][0];
  assign out_data_o.m01 = m_q[0][1];
  assign out_data_o.m02 = m_q[0][2];
  assign out_data_o.m10 = m_q[1][0];
  assign out_data_o.m11 = m_q[1][1];
  assign out_data_o.m12 = m_q[1][2];
  assign out_data_o.m20 = m_q[2][0];
  assign out_data_o.m21 = m_q[2][1];
  assign out_data_o.m22 = m_q[2][2];

  `ERM_ASSERT(a_full_when_blocked, !in_ready_o |-> &v_q, "input blocked with an empty stage")
  `ERM_ASSERT(a_accept_enters, in_valid_i && in_ready_o |=> v_q[0], "accepted transaction lost")
  `ERM_ASSERT_NEVER(a_m22_range, out_valid_o && (out_data_o.m22 > 16'sd4096 || out_data_o.m22 < -16'sd4096), "m22 out of range")

endmodule

/* rtl/core/erm_sine.sv */
module erm_sine (
  input  logic                                clk_i,
  input  logic [erm_pkg::SinStages-1:0]       en_i,
  input  logic [11:0]                         angle_i,
  output logic signed [13:0]                  sin_o
);

  logic [10:0] ph;
  logic [10:0] x;
  logic [11:0] w;
  logic [22:0] prod;
  logic [20:0] p_q;
  logic [24:0] den;
  logic [36:0] num;
  logic        ng_q [0:14];
  logic [37:0] rem_q [0:13];
  logic [24:0] den_q [0:12];
  logic [12:0] q_q [1:13];

  assign ph   = angle_i[10:0];
  assign x    = (ph <= 11'd1024) ? ph : 11'(12'd2048 - {1'b0, ph});
  assign w    = 12'd2048 - {1'b0, x};
  assign prod = 23'(x) * 23'(w);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q      <= prod[20:0];
      ng_q[0]  <= angle_i[11];
    end
  end

  assign num = {p_q, 16'b0};
  assign den = 25'd20971520 - {2'b0, p_q, 2'b0};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rem_q[0] <= 38'(num) + 38'(den >> 1);
      den_q[0] <= den;
      ng_q[1]  <= ng_q[0];
    end
  end

  for (genvar i = 0; i < 13; i++) begin : g_step
    logic [37:0] sh;
    logic        ge;
    logic [12:0] qin;
    assign sh = 38'(den_q[i]) << (12 - i);
    assign ge = rem_q[i] >= sh;
    if (i == 0) begin : g_first
      assign qin = '0;
    end else begin : g_rest
      assign qin = q_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i[2+i]) begin
        rem_q[i+1] <= ge ? rem_q[i] - sh : rem_q[i];
        q_q[i+1]   <= qin | (13'(ge) << (12 - i));
        ng_q[i+2]  <= ng_q[i+1];
      end
    end
    if (i < 12) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i[2+i]) begin
          den_q[i+1] <= den_q[i];
        end
      end
    end
  end

  assign sin_o = ng_q[14] ? -$signed({1'b0, q_q[13]}) : $signed({1'b0, q_q[13]});

endmodule
